### sv/wgta_pkg.sv
// Shared types, codes and fixed-point constants for the windowed Goertzel
// tone amplitude block. Used by the controller, the datapath and the top level.
`default_nettype none

package wgta_pkg;

  // Fixed-point widths of the recurrence and the shared multiplier.
  localparam int Q_W      = 48;   // Goertzel delay width
  localparam int M_W      = 51;   // coefficient product after the Q2.30 shift
  localparam int ACC_W    = 100;  // accumulator for exact power and products
  localparam int MA_W     = 33;   // multiplier operand A (signed)
  localparam int MB_W     = 27;   // multiplier operand B (signed)
  localparam int P_W      = MA_W + MB_W;
  localparam int LIMB_W   = 24;   // limb width for split products
  localparam int ROOT_W   = 50;   // square root width
  localparam int REM_W    = ROOT_W + 3;
  localparam int CFG_W    = 32;
  localparam int W_W      = 17;   // Hann weight, 0 .. 32768
  localparam int COS_W    = 18;   // signed cosine, -32768 .. 32768

  localparam int X_SHIFT   = 7;
  localparam int M_SHIFT   = 30;
  localparam int AMP_SHIFT = 38;

  localparam logic [COS_W:0] COS_ONE = 19'd32768;

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Configuration register indexes.
  localparam logic [1:0] REG_COEFF = 2'd0;
  localparam logic [1:0] REG_STEP  = 2'd1;
  localparam logic [1:0] REG_SCALE = 2'd2;

  localparam logic [CFG_W-1:0] STEP_RESET  = 32'd8405024;
  localparam logic [CFG_W-1:0] SCALE_RESET = 32'd8405024;

  // Multiplier operand A selects.
  localparam logic [2:0] A_SAMPLE  = 3'd0;
  localparam logic [2:0] A_COEFF   = 3'd1;
  localparam logic [2:0] A_SCALE   = 3'd2;
  localparam logic [2:0] A_PREV_HI = 3'd3;
  localparam logic [2:0] A_PREV_LO = 3'd4;
  localparam logic [2:0] A_PRV2_HI = 3'd5;
  localparam logic [2:0] A_PRV2_LO = 3'd6;

  // Multiplier operand B selects.
  localparam logic [3:0] B_WIN     = 4'd0;
  localparam logic [3:0] B_PREV_HI = 4'd1;
  localparam logic [3:0] B_PREV_LO = 4'd2;
  localparam logic [3:0] B_PRV2_HI = 4'd3;
  localparam logic [3:0] B_PRV2_LO = 4'd4;
  localparam logic [3:0] B_T_HI    = 4'd5;
  localparam logic [3:0] B_T_LO    = 4'd6;
  localparam logic [3:0] B_ROOT_HI = 4'd7;
  localparam logic [3:0] B_ROOT_LO = 4'd8;

  // Partial product shifts.
  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_24 = 2'd1;
  localparam logic [1:0] SH_48 = 2'd2;

  // Accumulator operations.
  localparam logic [1:0] ACC_NOP  = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;
  localparam logic [1:0] ACC_SUB  = 2'd3;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic [2:0] a_sel;
    logic [3:0] b_sel;
    logic [1:0] sh;
    logic [1:0] acc_op;
    logic       x_we;
    logic       m_we;
    logic       load;
    logic       upd;
    logic       sq_init;
    logic       sq_step;
    logic       out_we;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic out_busy;
  } sts_t;

  localparam cmd_t CMD_IDLE = '0;

  // Twelve partial products of prev^2 + prev2^2 - prev*t.
  function automatic cmd_t pwr_uop(input logic [3:0] step);
    cmd_t c;
    c = CMD_IDLE;
    case (step)
      4'd0:  begin c.a_sel = A_PREV_HI; c.b_sel = B_PREV_HI; c.sh = SH_48; c.acc_op = ACC_LOAD; end
      4'd1:  begin c.a_sel = A_PREV_HI; c.b_sel = B_PREV_LO; c.sh = SH_24; c.acc_op = ACC_ADD; end
      4'd2:  begin c.a_sel = A_PREV_LO; c.b_sel = B_PREV_HI; c.sh = SH_24; c.acc_op = ACC_ADD; end
      4'd3:  begin c.a_sel = A_PREV_LO; c.b_sel = B_PREV_LO; c.sh = SH_0;  c.acc_op = ACC_ADD; end
      4'd4:  begin c.a_sel = A_PRV2_HI; c.b_sel = B_PRV2_HI; c.sh = SH_48; c.acc_op = ACC_ADD; end
      4'd5:  begin c.a_sel = A_PRV2_HI; c.b_sel = B_PRV2_LO; c.sh = SH_24; c.acc_op = ACC_ADD; end
      4'd6:  begin c.a_sel = A_PRV2_LO; c.b_sel = B_PRV2_HI; c.sh = SH_24; c.acc_op = ACC_ADD; end
      4'd7:  begin c.a_sel = A_PRV2_LO; c.b_sel = B_PRV2_LO; c.sh = SH_0;  c.acc_op = ACC_ADD; end
      4'd8:  begin c.a_sel = A_PREV_HI; c.b_sel = B_T_HI;    c.sh = SH_48; c.acc_op = ACC_SUB; end
      4'd9:  begin c.a_sel = A_PREV_HI; c.b_sel = B_T_LO;    c.sh = SH_24; c.acc_op = ACC_SUB; end
      4'd10: begin c.a_sel = A_PREV_LO; c.b_sel = B_T_HI;    c.sh = SH_24; c.acc_op = ACC_SUB; end
      4'd11: begin c.a_sel = A_PREV_LO; c.b_sel = B_T_LO;    c.sh = SH_0;  c.acc_op = ACC_SUB; end
      default: c = CMD_IDLE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/wgta_in_if.sv
// Sample channel: valid/ready handshake carrying one sample and its block end mark.
// Stand-alone; its width follows the sample width of the block.
`default_nettype none

interface wgta_in_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           last_sample;

  modport source(output valid, sample, last_sample, input ready);
  modport sink(input valid, sample, last_sample, output ready);
endinterface

`default_nettype wire

### sv/wgta_out_if.sv
// Result channel: valid/ready handshake carrying one tone amplitude.
// Stand-alone; its width is one bit more than the sample width.
`default_nettype none

interface wgta_out_if #(
  parameter int AMP_WIDTH = 17
) ();
  logic                 valid;
  logic                 ready;
  logic [AMP_WIDTH-1:0] amplitude;

  modport source(output valid, amplitude, input ready);
  modport sink(input valid, amplitude, output ready);
endinterface

`default_nettype wire

### sv/windowed_goertzel_tone_amplitude.sv
// Top level of the Hann-windowed single-bin Goertzel tone amplitude meter.
// Instantiates wgta_ctrl and wgta_dp; uses wgta_pkg, wgta_in_if and wgta_out_if.
`default_nettype none

// Each sample is weighted by a Hann window from a quarter-wave cosine table,
// fed to a 48-bit Goertzel recurrence, and on the sample marked last the block
// power is square-rooted, scaled and sent out as one amplitude item, after which
// the window phase and delays are cleared. A new sample is taken only once the
// previous one has passed the recurrence update, and after a last sample only once
// its amplitude is in the output register. The pace is set by the single shared
// 33x27 multiplier, which forms the 48-bit coefficient product in two passes and
// the exact block power in twelve, and by the root unit, which yields one of its
// 50 root bits per cycle. A finished amplitude waits in an output register, so
// new samples are taken while it is still unread. Configuration is written through
// cfg_we, cfg_index and cfg_data while idle; the user ensures it, the block does not.
module windowed_goertzel_tone_amplitude #(
  parameter int SAMPLE_WIDTH    = 16,
  parameter int COS_TABLE_DEPTH = 256
) (
  input  wire                          clk,
  input  wire                          rst,
  wgta_in_if.sink                      samples,
  wgta_out_if.source                   results,
  input  wire                          cfg_we,
  input  wire  [1:0]                   cfg_index,
  input  wire  [wgta_pkg::CFG_W-1:0]   cfg_data
);

  wgta_pkg::cmd_t cmd;
  wgta_pkg::sts_t sts;
  logic           in_ready;
  logic           out_valid;
  logic [SAMPLE_WIDTH:0] amplitude;

  // Sequencer.
  wgta_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic and storage.
  wgta_dp #(
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample      (samples.sample),
    .last_sample (samples.last_sample),
    .out_ready   (results.ready),
    .out_valid   (out_valid),
    .amplitude   (amplitude),
    .cmd         (cmd),
    .sts         (sts)
  );

  // Channel hookup.
  assign samples.ready     = in_ready;
  assign results.valid     = out_valid;
  assign results.amplitude = amplitude;

endmodule

`default_nettype wire

### sv/wgta_ctrl.sv
// Sequencer for the windowed Goertzel block: steps the shared multiplier,
// the recurrence update, the power sum and the square root. Uses wgta_pkg.
`default_nettype none

module wgta_ctrl (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_ready,
  input  wgta_pkg::sts_t  sts,
  output wgta_pkg::cmd_t  cmd
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_WIN  = 5'd1;
  localparam logic [4:0] ST_M1   = 5'd2;
  localparam logic [4:0] ST_M2   = 5'd3;
  localparam logic [4:0] ST_MW   = 5'd4;
  localparam logic [4:0] ST_UPD  = 5'd5;
  localparam logic [4:0] ST_T1   = 5'd6;
  localparam logic [4:0] ST_T2   = 5'd7;
  localparam logic [4:0] ST_TW   = 5'd8;
  localparam logic [4:0] ST_PWR  = 5'd9;
  localparam logic [4:0] ST_PD   = 5'd10;
  localparam logic [4:0] ST_SQI  = 5'd11;
  localparam logic [4:0] ST_SQ   = 5'd12;
  localparam logic [4:0] ST_SC1  = 5'd13;
  localparam logic [4:0] ST_SC2  = 5'd14;
  localparam logic [4:0] ST_SCW  = 5'd15;
  localparam logic [4:0] ST_OUT  = 5'd16;

  localparam logic [5:0] PWR_LAST = 6'd11;
  localparam logic [5:0] SQ_LAST  = 6'(wgta_pkg::ROOT_W - 1);

  logic [4:0] state, state_next;
  logic [5:0] cnt, cnt_next;

  // Next state, step counter and command decode.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = wgta_pkg::CMD_IDLE;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_WIN;
        end
      end
      ST_WIN: begin
        cmd.a_sel  = wgta_pkg::A_SAMPLE;
        cmd.b_sel  = wgta_pkg::B_WIN;
        cmd.x_we   = 1'b1;
        state_next = ST_M1;
      end
      ST_M1: begin
        cmd.a_sel  = wgta_pkg::A_COEFF;
        cmd.b_sel  = wgta_pkg::B_PREV_HI;
        cmd.sh     = wgta_pkg::SH_24;
        cmd.acc_op = wgta_pkg::ACC_LOAD;
        state_next = ST_M2;
      end
      ST_M2: begin
        cmd.a_sel  = wgta_pkg::A_COEFF;
        cmd.b_sel  = wgta_pkg::B_PREV_LO;
        cmd.sh     = wgta_pkg::SH_0;
        cmd.acc_op = wgta_pkg::ACC_ADD;
        cmd.m_we   = 1'b1;
        state_next = ST_MW;
      end
      ST_MW: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd    = 1'b1;
        state_next = sts.last ? ST_T1 : ST_IDLE;
      end
      ST_T1: begin
        cmd.a_sel  = wgta_pkg::A_COEFF;
        cmd.b_sel  = wgta_pkg::B_PRV2_HI;
        cmd.sh     = wgta_pkg::SH_24;
        cmd.acc_op = wgta_pkg::ACC_LOAD;
        state_next = ST_T2;
      end
      ST_T2: begin
        cmd.a_sel  = wgta_pkg::A_COEFF;
        cmd.b_sel  = wgta_pkg::B_PRV2_LO;
        cmd.sh     = wgta_pkg::SH_0;
        cmd.acc_op = wgta_pkg::ACC_ADD;
        cmd.m_we   = 1'b1;
        state_next = ST_TW;
      end
      ST_TW: begin
        cnt_next   = '0;
        state_next = ST_PWR;
      end
      ST_PWR: begin
        cmd      = wgta_pkg::pwr_uop(cnt[3:0]);
        cnt_next = cnt + 6'd1;
        if (cnt == PWR_LAST) begin
          state_next = ST_PD;
        end
      end
      ST_PD: begin
        state_next = ST_SQI;
      end
      ST_SQI: begin
        cmd.sq_init = 1'b1;
        cnt_next    = '0;
        state_next  = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq_step = 1'b1;
        cnt_next    = cnt + 6'd1;
        if (cnt == SQ_LAST) begin
          state_next = ST_SC1;
        end
      end
      ST_SC1: begin
        cmd.a_sel  = wgta_pkg::A_SCALE;
        cmd.b_sel  = wgta_pkg::B_ROOT_LO;
        cmd.sh     = wgta_pkg::SH_0;
        cmd.acc_op = wgta_pkg::ACC_LOAD;
        state_next = ST_SC2;
      end
      ST_SC2: begin
        cmd.a_sel  = wgta_pkg::A_SCALE;
        cmd.b_sel  = wgta_pkg::B_ROOT_HI;
        cmd.sh     = wgta_pkg::SH_24;
        cmd.acc_op = wgta_pkg::ACC_ADD;
        state_next = ST_SCW;
      end
      ST_SCW: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_we = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // The root loop never runs past its last bit.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQ) |-> (cnt <= SQ_LAST))
    else $error("square root step counter overran");

endmodule

`default_nettype wire

### sv/wgta_dp.sv
// Datapath of the windowed Goertzel block: configuration registers, cosine
// table, shared multiplier with accumulator, recurrence, root unit, output register.
// Uses wgta_pkg; driven by wgta_ctrl.
`default_nettype none

module wgta_dp #(
  parameter int SAMPLE_WIDTH    = 16,
  parameter int COS_TABLE_DEPTH = 256
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_we,
  input  wire  [1:0]                          cfg_index,
  input  wire  [wgta_pkg::CFG_W-1:0]          cfg_data,
  input  wire  signed [SAMPLE_WIDTH-1:0]      sample,
  input  wire                                 last_sample,
  input  wire                                 out_ready,
  output logic                                out_valid,
  output logic [SAMPLE_WIDTH:0]               amplitude,
  input  wgta_pkg::cmd_t                      cmd,
  output wgta_pkg::sts_t                      sts
);

  localparam int AMP_W  = SAMPLE_WIDTH + 1;
  localparam int IDX_W  = $clog2(COS_TABLE_DEPTH + 1);
  localparam int FRAC_W = 30 + IDX_W;
  localparam int MA_W   = wgta_pkg::MA_W;
  localparam int MB_W   = wgta_pkg::MB_W;
  localparam int P_W    = wgta_pkg::P_W;
  localparam int ACC_W  = wgta_pkg::ACC_W;
  localparam int Q_W    = wgta_pkg::Q_W;
  localparam int M_W    = wgta_pkg::M_W;
  localparam int L      = wgta_pkg::LIMB_W;
  localparam int ROOT_W = wgta_pkg::ROOT_W;
  localparam int REM_W  = wgta_pkg::REM_W;
  localparam int W_W    = wgta_pkg::W_W;
  localparam int COS_W  = wgta_pkg::COS_W;

  // One quarter-wave table entry, built by a truncated Taylor series in Q30.
  // An entry at or above full scale less one stands for exactly one.
  function automatic logic [W_W-1:0] cos_entry(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint          c;
    x  = (wgta_pkg::HALF_PI_Q30 * 64'(k)) / 64'(COS_TABLE_DEPTH);
    x2 = (x * x) >> 30;
    t  = wgta_pkg::Q30_ONE;
    t  = wgta_pkg::Q30_ONE - ((x2 * t) >> 30) / 90;
    t  = wgta_pkg::Q30_ONE - ((x2 * t) >> 30) / 56;
    t  = wgta_pkg::Q30_ONE - ((x2 * t) >> 30) / 30;
    t  = wgta_pkg::Q30_ONE - ((x2 * t) >> 30) / 12;
    c  = longint'(wgta_pkg::Q30_ONE) - longint'(((x2 * t) >> 30) / 2);
    if (c <= 0) begin
      c = 0;
    end else begin
      c = (c + 16384) >>> 15;
    end
    if (c >= 32767) begin
      c = 32768;
    end
    return W_W'(c);
  endfunction

  // Constant cosine table over a quarter turn, endpoints included.
  logic [W_W-1:0] cos_rom [0:COS_TABLE_DEPTH];

  for (genvar k = 0; k <= COS_TABLE_DEPTH; k++) begin : g_rom
    assign cos_rom[k] = cos_entry(k);
  end

  // Configuration and block state.
  logic signed [wgta_pkg::CFG_W-1:0] coeff;
  logic [wgta_pkg::CFG_W-1:0]        step;
  logic [wgta_pkg::CFG_W-1:0]        scale;
  logic [31:0]                       phase;
  logic signed [Q_W-1:0]             prev;
  logic signed [Q_W-1:0]             prev2;

  // Working registers.
  logic signed [SAMPLE_WIDTH-1:0] sample_r;
  logic                           last_r;
  logic signed [COS_W-1:0]        cos_r;
  logic signed [Q_W-1:0]          x_r;
  logic signed [M_W-1:0]          m_r;
  logic signed [P_W-1:0]          prod_r;
  logic signed [ACC_W-1:0]        acc;
  logic [1:0]                     d_op;
  logic [1:0]                     d_sh;
  logic                           d_x_we;
  logic                           d_m_we;
  logic [ACC_W-1:0]               rad;
  logic [REM_W-1:0]               rem;
  logic [ROOT_W-1:0]              root;

  // Cosine lookup from the current window phase.
  logic [FRAC_W-1:0]       frac_prod;
  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        ridx;
  logic [W_W-1:0]          rom_val;
  logic signed [COS_W-1:0] cos_next;

  always_comb begin
    frac_prod = {{IDX_W{1'b0}}, phase[29:0]} * FRAC_W'(COS_TABLE_DEPTH);
    idx       = frac_prod[FRAC_W-1:30];
    ridx      = phase[30] ? (IDX_W'(COS_TABLE_DEPTH) - idx) : idx;
    rom_val   = cos_rom[ridx];
    cos_next  = (phase[31] ^ phase[30]) ? -$signed({1'b0, rom_val})
                                        : $signed({1'b0, rom_val});
  end

  // Hann weight (1 - cos) / 2 in Q1.15.
  logic signed [COS_W:0] w_full;
  logic [W_W-1:0]        w;

  always_comb begin
    w_full = $signed(wgta_pkg::COS_ONE) - $signed({cos_r[COS_W-1], cos_r});
    w      = w_full[W_W:1];
  end

  // Operand selection for the shared multiplier.
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;

  always_comb begin
    case (cmd.a_sel)
      wgta_pkg::A_SAMPLE:
        mul_a = $signed({{(MA_W-SAMPLE_WIDTH){sample_r[SAMPLE_WIDTH-1]}}, sample_r});
      wgta_pkg::A_COEFF:   mul_a = $signed({coeff[wgta_pkg::CFG_W-1], coeff});
      wgta_pkg::A_SCALE:   mul_a = $signed({1'b0, scale});
      wgta_pkg::A_PREV_HI: mul_a = $signed({{(MA_W-L){prev[Q_W-1]}}, prev[Q_W-1:L]});
      wgta_pkg::A_PREV_LO: mul_a = $signed({{(MA_W-L){1'b0}}, prev[L-1:0]});
      wgta_pkg::A_PRV2_HI: mul_a = $signed({{(MA_W-L){prev2[Q_W-1]}}, prev2[Q_W-1:L]});
      wgta_pkg::A_PRV2_LO: mul_a = $signed({{(MA_W-L){1'b0}}, prev2[L-1:0]});
      default:             mul_a = '0;
    endcase
    case (cmd.b_sel)
      wgta_pkg::B_WIN:     mul_b = $signed({{(MB_W-W_W){1'b0}}, w});
      wgta_pkg::B_PREV_HI: mul_b = $signed({{(MB_W-L){prev[Q_W-1]}}, prev[Q_W-1:L]});
      wgta_pkg::B_PREV_LO: mul_b = $signed({{(MB_W-L){1'b0}}, prev[L-1:0]});
      wgta_pkg::B_PRV2_HI: mul_b = $signed({{(MB_W-L){prev2[Q_W-1]}}, prev2[Q_W-1:L]});
      wgta_pkg::B_PRV2_LO: mul_b = $signed({{(MB_W-L){1'b0}}, prev2[L-1:0]});
      wgta_pkg::B_T_HI:    mul_b = $signed(m_r[M_W-1:L]);
      wgta_pkg::B_T_LO:    mul_b = $signed({{(MB_W-L){1'b0}}, m_r[L-1:0]});
      wgta_pkg::B_ROOT_HI: mul_b = $signed({1'b0, root[ROOT_W-1:L]});
      wgta_pkg::B_ROOT_LO: mul_b = $signed({{(MB_W-L){1'b0}}, root[L-1:0]});
      default:             mul_b = '0;
    endcase
  end

  // Accumulator stage, fed by the registered multiplier product.
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] prod_sh;
  logic signed [ACC_W-1:0] sum;
  logic signed [P_W-1:0]   x_full;
  logic signed [ACC_W-1:0] m_full;

  always_comb begin
    prod_ext = $signed({{(ACC_W-P_W){prod_r[P_W-1]}}, prod_r});
    case (d_sh)
      wgta_pkg::SH_24: prod_sh = prod_ext <<< L;
      wgta_pkg::SH_48: prod_sh = prod_ext <<< (2 * L);
      default:         prod_sh = prod_ext;
    endcase
    unique case (d_op)
      wgta_pkg::ACC_LOAD: sum = prod_sh;
      wgta_pkg::ACC_ADD:  sum = acc + prod_sh;
      wgta_pkg::ACC_SUB:  sum = acc - prod_sh;
      default:            sum = acc;
    endcase
    x_full = prod_r >>> wgta_pkg::X_SHIFT;
    m_full = sum >>> wgta_pkg::M_SHIFT;
  end

  // Recurrence q0 = x + coeff*q1 - q2, wrapping at 48 bits.
  logic signed [Q_W-1:0] q0;
  assign q0 = x_r + $signed(m_r[Q_W-1:0]) - prev2;

  // One root bit per step from two radicand bits.
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  always_comb begin
    rem_sh = {rem[REM_W-3:0], rad[ACC_W-1:ACC_W-2]};
    trial  = {1'b0, root, 2'b01};
  end

  // Scaled amplitude with saturation.
  localparam int SAT_LO = wgta_pkg::AMP_SHIFT + AMP_W;
  logic [AMP_W-1:0] amp_next;
  always_comb begin
    if (acc[ACC_W-1:SAT_LO] != '0) begin
      amp_next = '1;
    end else begin
      amp_next = acc[SAT_LO-1:wgta_pkg::AMP_SHIFT];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      coeff <= '0;
      step  <= wgta_pkg::STEP_RESET;
      scale <= wgta_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wgta_pkg::REG_COEFF: coeff <= $signed(cfg_data);
        wgta_pkg::REG_STEP:  step  <= cfg_data;
        wgta_pkg::REG_SCALE: scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // Block state: phase and Goertzel delays, cleared after each result.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      prev  <= '0;
      prev2 <= '0;
    end else if (cmd.out_we) begin
      phase <= '0;
      prev  <= '0;
      prev2 <= '0;
    end else begin
      if (cmd.load) begin
        phase <= phase + step;
      end
      if (cmd.upd) begin
        prev2 <= prev;
        prev  <= q0;
      end
    end
  end

  // Accepted item and its cosine.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= sample;
      cos_r    <= cos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_r <= 1'b0;
    end else if (cmd.load) begin
      last_r <= last_sample;
    end
  end

  // Multiplier and accumulator pipeline.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    acc    <= sum;
    if (d_x_we) begin
      x_r <= x_full[Q_W-1:0];
    end
    if (d_m_we) begin
      m_r <= m_full[M_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_op   <= wgta_pkg::ACC_NOP;
      d_sh   <= wgta_pkg::SH_0;
      d_x_we <= 1'b0;
      d_m_we <= 1'b0;
    end else begin
      d_op   <= cmd.acc_op;
      d_sh   <= cmd.sh;
      d_x_we <= cmd.x_we;
      d_m_we <= cmd.m_we;
    end
  end

  // Restoring square root, negative power clamped to zero.
  always_ff @(posedge clk) begin
    if (cmd.sq_init) begin
      rad  <= acc[ACC_W-1] ? '0 : acc;
      rem  <= '0;
      root <= '0;
    end else if (cmd.sq_step) begin
      rad <= rad << 2;
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_we) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_we) begin
      amplitude <= amp_next;
    end
  end

  assign sts.last     = last_r;
  assign sts.out_busy = out_valid && !out_ready;

  // A new result never overwrites one still waiting.
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_we |-> !(out_valid && !out_ready))
    else $error("result written over a pending item");

  // Emitting a result leaves the block state cleared.
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_we |=> (prev == '0) && (prev2 == '0) && (phase == '0))
    else $error("block state not cleared after a result");

  // A result appears only when the sequencer writes one.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_we))
    else $error("result valid without a write");

endmodule

`default_nettype wire
